// File: design/text_console_line_editor_core_macros.svh
// Assertion helpers for the console line editor datapath.
`ifndef TEXT_CONSOLE_LINE_EDITOR_CORE_MACROS_SVH
`define TEXT_CONSOLE_LINE_EDITOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked on clk, switched off while rst_n is low
`define TCLE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked on clk, also checked during reset
`define TCLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCLE_ASSERT_RST(label, prop, msg)
`define TCLE_ASSERT(label, prop, msg)
`endif

`endif

// File: design/tcle_pkg.sv
package tcle_pkg;

    localparam int COLUMNS_DEF    = 160;
    localparam int STORE_ROWS_DEF = 128;

    localparam int VIS_W      = 7;
    localparam int HIST_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int VIS_MAX    = 64;

    localparam logic [VIS_W-1:0]  VIS_RESET  = 7'd24;
    localparam logic [HIST_W-1:0] HIST_RESET = 8'd100;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        KIND_PUT  = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DOWN = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VISIBLE = 2'd0,
        REG_HISTORY = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [5:0] view_row;
        logic [7:0] column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
        logic [6:0] view_base;
        logic [7:0] cell_char;
        logic       at_cursor;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_CELL, ST_NL,
        ST_SH_RD, ST_SH_WR, ST_SH_BL, ST_BS,
        ST_DEL_RD, ST_DEL_WR, ST_DEL_NX, ST_DEL_FIRST,
        ST_SC_RD, ST_SC_CHK, ST_MG_CHK, ST_MG_FIRST, ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_CLEAR, CMD_LOAD, CMD_SCROLL_UP, CMD_SCROLL_DN,
        CMD_CELL_RD, CMD_CELL_CAP, CMD_PUT, CMD_NL,
        CMD_SH_RD, CMD_SH_WR, CMD_SH_BL,
        CMD_BS_MID, CMD_BS_COL0,
        CMD_DEL_RD, CMD_DEL_BL, CMD_DEL_WR, CMD_DEL_NX, CMD_DEL_FIRST,
        CMD_SC_RD, CMD_SC_STEP, CMD_TAIL_WR, CMD_MERGE_SET,
        CMD_MG_RD, CMD_MG_WR, CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic  clear_last;
        kind_t kind;
        logic  is_nl;
        logic  is_bs;
        logic  in_range;
        logic  put_wrap;
        logic  nl_shift;
        logic  sh_copy;
        logic  sh_last;
        logic  bs_mid;
        logic  bs_top;
        logic  del_shift;
        logic  del_last_row;
        logic  rdata_blank;
        logic  i_zero;
        logic  mg_go;
        logic  out_full;
    } dp_status_t;

endpackage

// File: design/tcle_datapath.sv
`include "text_console_line_editor_core_macros.svh"

module tcle_datapath #(
    parameter int COLUMNS    = tcle_pkg::COLUMNS_DEF,
    parameter int STORE_ROWS = tcle_pkg::STORE_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcle_pkg::dp_cmd_t               cmd,
    output tcle_pkg::dp_status_t            status,
    input  tcle_pkg::in_item_t              in_data,
    input  logic                            cfg_valid,
    input  logic [tcle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcle_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tcle_pkg::out_item_t             out_data
);
    import tcle_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COL_W1 = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(STORE_ROWS);
    localparam int DEPTH  = STORE_ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ADDR_W + 1;
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

    logic [7:0] text_mem [DEPTH];

    logic [VIS_W-1:0]  vis_cfg_reg, vis_cfg_next;
    logic [HIST_W-1:0] hist_cfg_reg, hist_cfg_next;
    logic [COL_W-1:0]  cc_reg, cc_next;
    logic [5:0]        cl_reg, cl_next;
    logic [ROW_W-1:0]  vt_reg, vt_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  prev_reg, prev_next;
    logic [COL_W-1:0]  i_reg, i_next;
    logic [COL_W1-1:0] cur_reg, cur_next;
    logic [7:0]        first_reg, first_next;
    in_item_t          item_reg, item_next;
    logic [7:0]        cell_reg, cell_next;
    logic              hit_reg, hit_next;
    out_item_t         out_reg, out_next;
    logic [7:0]        rdata_reg;

    logic              we, re;
    logic [ADDR_W-1:0] wa, ra;
    logic [7:0]        wd;

    logic [8:0]        vis9, hist9;
    logic [8:0]        row_cur9, vrow9, row_nx9, prev_nx9, vt9;
    logic [ROW_W-1:0]  row_cur;
    logic              vt_room, cl_below, rdata_blank;
    logic [COL_W-1:0]  i_inc, merge_col;
    logic [COL_W1-1:0] tailp_now;
    logic [SUM_W-1:0]  copy_lim, sh_end;

    // effective register values
    always_comb
    begin
        vis9 = {2'b00, vis_cfg_reg};
        if (vis9 < 9'd1) vis9 = 9'd1;
        if (vis9 > 9'(VIS_MAX)) vis9 = 9'(VIS_MAX);
        if (vis9 > 9'(STORE_ROWS)) vis9 = 9'(STORE_ROWS);
        hist9 = {1'b0, hist_cfg_reg};
        if (hist9 < vis9) hist9 = vis9;
        if (hist9 > 9'(STORE_ROWS)) hist9 = 9'(STORE_ROWS);
    end

    assign row_cur9    = 9'(vt_reg) + 9'(cl_reg);
    assign row_cur     = row_cur9[ROW_W-1:0];
    assign vrow9       = 9'(vt_reg) + 9'(item_reg.view_row);
    assign row_nx9     = 9'(row_reg) + 9'd1;
    assign prev_nx9    = 9'(prev_reg) + 9'd1;
    assign vt9         = 9'(vt_reg);
    assign vt_room     = (vt9 + vis9) < hist9;
    assign cl_below    = 9'(cl_reg) < (vis9 - 9'd1);
    assign rdata_blank = rdata_reg == CH_SPACE;
    assign i_inc       = i_reg + COL_W'(1);
    assign tailp_now   = rdata_blank ? '0 : (COL_W1'(i_reg) + COL_W1'(1));
    assign merge_col   = (tailp_now > COL_W1'(COLUMNS - 1)) ? COL_LAST
                                                             : tailp_now[COL_W-1:0];
    assign copy_lim    = SUM_W'(32'(hist9 - 9'd1) * COLUMNS);
    assign sh_end      = SUM_W'(32'(hist9) * COLUMNS - 1);

    // store port selection
    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = CH_SPACE;
        re = 1'b0;
        ra = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                we = 1'b1;
                wa = sweep_reg;
            end
            CMD_CELL_RD:
            begin
                re = 1'b1;
                ra = cell_addr(vrow9[ROW_W-1:0], item_reg.column[COL_W-1:0]);
            end
            CMD_PUT:
            begin
                we = 1'b1;
                wa = cell_addr(row_cur, cc_reg);
                wd = item_reg.char_code;
            end
            CMD_SH_RD:
            begin
                re = 1'b1;
                ra = ADDR_W'(SUM_W'(sweep_reg) + SUM_W'(COLUMNS));
            end
            CMD_SH_WR:
            begin
                we = 1'b1;
                wa = sweep_reg;
                wd = rdata_reg;
            end
            CMD_SH_BL:
            begin
                we = 1'b1;
                wa = sweep_reg;
            end
            CMD_DEL_RD:
            begin
                re = 1'b1;
                ra = cell_addr(row_reg, i_inc);
            end
            CMD_DEL_BL:
            begin
                we = 1'b1;
                wa = cell_addr(row_reg, COL_LAST);
            end
            CMD_DEL_WR:
            begin
                we = 1'b1;
                wa = cell_addr(row_reg, i_reg);
                wd = rdata_reg;
            end
            CMD_DEL_NX:
            begin
                re = 1'b1;
                ra = cell_addr(row_nx9[ROW_W-1:0], '0);
            end
            CMD_SC_RD:
            begin
                re = 1'b1;
                ra = cell_addr(row_reg, i_reg);
            end
            CMD_TAIL_WR:
            begin
                we = 1'b1;
                wa = cell_addr(row_reg, tailp_now[COL_W-1:0]);
                wd = first_reg;
            end
            CMD_MG_RD:
            begin
                re = 1'b1;
                ra = cell_addr(prev_nx9[ROW_W-1:0], '0);
            end
            CMD_MG_WR:
            begin
                we = 1'b1;
                wa = cell_addr(prev_reg, cur_reg[COL_W-1:0]);
                wd = rdata_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            text_mem[wa] <= wd;
        end
        if (re)
        begin
            rdata_reg <= text_mem[ra];
        end
    end

    always_comb
    begin
        vis_cfg_next   = vis_cfg_reg;
        hist_cfg_next  = hist_cfg_reg;
        cc_next        = cc_reg;
        cl_next        = cl_reg;
        vt_next        = vt_reg;
        sweep_next     = sweep_reg;
        out_valid_next = out_valid_reg && !out_ready;
        row_next       = row_reg;
        prev_next      = prev_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        item_next      = item_reg;
        cell_next      = cell_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;

        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VISIBLE: vis_cfg_next  = cfg_data[VIS_W-1:0];
                REG_HISTORY: hist_cfg_next = cfg_data[HIST_W-1:0];
                default:
                begin
                end
            endcase
        end

        case (cmd)
            CMD_CLEAR: sweep_next = sweep_reg + ADDR_W'(1);
            CMD_LOAD:
            begin
                item_next = in_data;
                cell_next = '0;
                hit_next  = 1'b0;
                if (9'(cl_reg) > (vis9 - 9'd1)) cl_next = 6'(vis9 - 9'd1);
                if ((vt9 + vis9) > hist9) vt_next = ROW_W'(hist9 - vis9);
                if (cc_reg > COL_LAST) cc_next = COL_LAST;
            end
            CMD_SCROLL_UP:
            begin
                if (vt_reg != '0) vt_next = vt_reg - ROW_W'(1);
            end
            CMD_SCROLL_DN:
            begin
                if (vt_room) vt_next = vt_reg + ROW_W'(1);
            end
            CMD_CELL_CAP:
            begin
                cell_next = rdata_reg;
                hit_next  = (item_reg.view_row == cl_reg) &&
                            (item_reg.column == 8'(cc_reg));
            end
            CMD_PUT: cc_next = (cc_reg == COL_LAST) ? '0 : (cc_reg + COL_W'(1));
            CMD_NL:
            begin
                cc_next = '0;
                if (cl_below) cl_next = cl_reg + 6'd1;
                else if (vt_room) vt_next = vt_reg + ROW_W'(1);
                else sweep_next = '0;
            end
            CMD_SH_WR, CMD_SH_BL: sweep_next = sweep_reg + ADDR_W'(1);
            CMD_BS_MID:
            begin
                cc_next  = cc_reg - COL_W'(1);
                i_next   = cc_reg - COL_W'(1);
                row_next = row_cur;
            end
            CMD_BS_COL0:
            begin
                if (cl_reg != '0) cl_next = cl_reg - 6'd1;
                else vt_next = vt_reg - ROW_W'(1);
                row_next  = row_cur - ROW_W'(1);
                prev_next = row_cur - ROW_W'(1);
                i_next    = COL_LAST;
            end
            CMD_DEL_WR: i_next = i_inc;
            CMD_DEL_FIRST:
            begin
                first_next = rdata_reg;
                i_next     = COL_LAST;
            end
            CMD_SC_STEP: i_next = i_reg - COL_W'(1);
            CMD_TAIL_WR:
            begin
                row_next = row_nx9[ROW_W-1:0];
                i_next   = '0;
            end
            CMD_MERGE_SET:
            begin
                cur_next = COL_W1'(merge_col);
                cc_next  = merge_col;
            end
            CMD_MG_WR:
            begin
                cur_next = cur_reg + COL_W1'(1);
                row_next = prev_nx9[ROW_W-1:0];
                i_next   = '0;
            end
            CMD_EMIT:
            begin
                out_valid_next       = 1'b1;
                out_next.cursor_col  = 8'(cc_reg);
                out_next.cursor_row  = cl_reg;
                out_next.view_base   = vt9[6:0];
                out_next.cell_char   = cell_reg;
                out_next.at_cursor   = hit_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_cfg_reg   <= VIS_RESET;
            hist_cfg_reg  <= HIST_RESET;
            cc_reg        <= '0;
            cl_reg        <= '0;
            vt_reg        <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vis_cfg_reg   <= vis_cfg_next;
            hist_cfg_reg  <= hist_cfg_next;
            cc_reg        <= cc_next;
            cl_reg        <= cl_next;
            vt_reg        <= vt_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        prev_reg  <= prev_next;
        i_reg     <= i_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        item_reg  <= item_next;
        cell_reg  <= cell_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        status.clear_last   = sweep_reg == ADDR_LAST;
        status.kind         = item_reg.kind;
        status.is_nl        = (item_reg.char_code == CH_LF) || (item_reg.char_code == CH_CR);
        status.is_bs        = (item_reg.char_code == CH_BS) || (item_reg.char_code == CH_DEL);
        status.in_range     = (9'(item_reg.view_row) < vis9) &&
                              (9'(item_reg.column) < 9'(COLUMNS));
        status.put_wrap     = cc_reg == COL_LAST;
        status.nl_shift     = !cl_below && !vt_room;
        status.sh_copy      = SUM_W'(sweep_reg) < copy_lim;
        status.sh_last      = SUM_W'(sweep_reg) == sh_end;
        status.bs_mid       = cc_reg != '0;
        status.bs_top       = (cl_reg == '0) && (vt_reg == '0);
        status.del_shift    = i_reg != COL_LAST;
        status.del_last_row = row_nx9 >= hist9;
        status.rdata_blank  = rdata_blank;
        status.i_zero       = i_reg == '0;
        status.mg_go        = (cur_reg < COL_W1'(COLUMNS)) && (prev_nx9 < hist9);
        status.out_full     = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `TCLE_ASSERT_RST(a_wr_in_store, we |-> (32'(wa) < DEPTH), "store write beyond the array")
    `TCLE_ASSERT_RST(a_tail_in_row, (cmd == CMD_TAIL_WR) |-> (tailp_now < COL_W1'(COLUMNS)), "reflow tail past row end")
    `TCLE_ASSERT_RST(a_merge_in_row, (cmd == CMD_MG_WR) |-> (cur_reg < COL_W1'(COLUMNS)), "merge column past row end")

endmodule

// File: design/tcle_ctrl.sv
module tcle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcle_pkg::dp_status_t status,
    output tcle_pkg::dp_cmd_t    cmd
);
    import tcle_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        ctx_merge_reg, ctx_merge_next;  // scan feeds a row merge
    logic        ret_merge_reg, ret_merge_next;  // delete returns to the merge loop

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ctx_merge_reg <= 1'b0;
            ret_merge_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_merge_reg <= ctx_merge_next;
            ret_merge_reg <= ret_merge_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctx_merge_next = ctx_merge_reg;
        ret_merge_next = ret_merge_reg;
        cmd            = CMD_NOP;
        in_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.kind)
                    KIND_PUT:
                    begin
                        if (status.is_nl) state_next = ST_NL;
                        else if (status.is_bs) state_next = ST_BS;
                        else
                        begin
                            cmd        = CMD_PUT;
                            state_next = status.put_wrap ? ST_NL : ST_DONE;
                        end
                    end
                    KIND_UP:
                    begin
                        cmd        = CMD_SCROLL_UP;
                        state_next = ST_DONE;
                    end
                    KIND_DOWN:
                    begin
                        cmd        = CMD_SCROLL_DN;
                        state_next = ST_DONE;
                    end
                    KIND_READ:
                    begin
                        if (status.in_range)
                        begin
                            cmd        = CMD_CELL_RD;
                            state_next = ST_CELL;
                        end
                        else state_next = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CELL:
            begin
                cmd        = CMD_CELL_CAP;
                state_next = ST_DONE;
            end
            ST_NL:
            begin
                cmd        = CMD_NL;
                state_next = status.nl_shift ? ST_SH_RD : ST_DONE;
            end
            ST_SH_RD:
            begin
                if (status.sh_copy)
                begin
                    cmd        = CMD_SH_RD;
                    state_next = ST_SH_WR;
                end
                else state_next = ST_SH_BL;
            end
            ST_SH_WR:
            begin
                cmd        = CMD_SH_WR;
                state_next = ST_SH_RD;
            end
            ST_SH_BL:
            begin
                cmd = CMD_SH_BL;
                if (status.sh_last) state_next = ST_DONE;
            end
            ST_BS:
            begin
                if (status.bs_mid)
                begin
                    cmd            = CMD_BS_MID;
                    ret_merge_next = 1'b0;
                    state_next     = ST_DEL_RD;
                end
                else if (status.bs_top) state_next = ST_DONE;
                else
                begin
                    cmd            = CMD_BS_COL0;
                    ctx_merge_next = 1'b1;
                    state_next     = ST_SC_RD;
                end
            end
            ST_DEL_RD:
            begin
                if (status.del_shift)
                begin
                    cmd        = CMD_DEL_RD;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cmd        = CMD_DEL_BL;
                    state_next = ST_DEL_NX;
                end
            end
            ST_DEL_WR:
            begin
                cmd        = CMD_DEL_WR;
                state_next = ST_DEL_RD;
            end
            ST_DEL_NX:
            begin
                if (status.del_last_row)
                    state_next = ret_merge_reg ? ST_MG_CHK : ST_DONE;
                else
                begin
                    cmd        = CMD_DEL_NX;
                    state_next = ST_DEL_FIRST;
                end
            end
            ST_DEL_FIRST:
            begin
                if (status.rdata_blank)
                    state_next = ret_merge_reg ? ST_MG_CHK : ST_DONE;
                else
                begin
                    cmd            = CMD_DEL_FIRST;
                    ctx_merge_next = 1'b0;
                    state_next     = ST_SC_RD;
                end
            end
            ST_SC_RD:
            begin
                cmd        = CMD_SC_RD;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                if (!status.rdata_blank || status.i_zero)
                begin
                    if (ctx_merge_reg)
                    begin
                        cmd        = CMD_MERGE_SET;
                        state_next = ST_MG_CHK;
                    end
                    else
                    begin
                        cmd        = CMD_TAIL_WR;
                        state_next = ST_DEL_RD;
                    end
                end
                else
                begin
                    cmd        = CMD_SC_STEP;
                    state_next = ST_SC_RD;
                end
            end
            ST_MG_CHK:
            begin
                if (status.mg_go)
                begin
                    cmd        = CMD_MG_RD;
                    state_next = ST_MG_FIRST;
                end
                else state_next = ST_DONE;
            end
            ST_MG_FIRST:
            begin
                if (status.rdata_blank) state_next = ST_DONE;
                else
                begin
                    cmd            = CMD_MG_WR;
                    ret_merge_next = 1'b1;
                    state_next     = ST_DEL_RD;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd        = CMD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/text_console_line_editor_core.sv
// Console line editor: one scrolling text region over a store of STORE_ROWS
// rows by COLUMNS bytes. Each input transaction returns exactly one result
// transaction carrying the cursor, the view offset and, for a cell read, the
// byte read. After reset the store is swept to spaces, one byte a cycle, and
// input is held off until the sweep ends; configuration writes are taken at
// any time. The store is a single array with one write and one registered
// read per cycle, and that port sets the timing: a newline on the last line
// with the view at the bottom copies the history up row by row; a backspace
// shifts the rest of its row byte by byte and scans backward over each row
// that gives up a byte in the reflow chain.
module text_console_line_editor_core #(
    parameter int COLUMNS    = tcle_pkg::COLUMNS_DEF,
    parameter int STORE_ROWS = tcle_pkg::STORE_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tcle_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tcle_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcle_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcle_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // register writes land in the cycle after they are offered
    assign cfg_ready = 1'b1;

    // sequencer: walks the edit, shift and reflow loops
    tcle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store, cursor, view and the result register
    tcle_datapath #(
        .COLUMNS    (COLUMNS),
        .STORE_ROWS (STORE_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: bench/tcle_checker.sv
`timescale 1ns / 100ps

// Watches the editor's channels, keeps its own copy of the console and flags
// any result that differs from what that copy says.
module tcle_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  tcle_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  tcle_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tcle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcle_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import tcle_pkg::*;

    localparam int NCOL = COLUMNS_DEF;
    localparam int NROW = STORE_ROWS_DEF;

    logic [7:0]  screen [NROW][NCOL];
    int          cur_col, cur_line, top_row;
    logic [6:0]  vis_reg;
    logic [7:0]  hist_reg;
    out_item_t   due_q [$];

    assign pending = due_q.size();

    function automatic int last_nonblank(int r);
        int i;
        i = NCOL - 1;
        while (i >= 0 && screen[r][i] == CH_SPACE)
            i--;
        return i;
    endfunction

    // remove one byte and pull the head of each following row up the chain
    task automatic delete_cell(int r, int x, int h);
        logic [7:0] head;
        int tail;
        forever
        begin
            for (int i = x; i + 1 < NCOL; i++)
                screen[r][i] = screen[r][i+1];
            screen[r][NCOL-1] = CH_SPACE;
            if (r + 1 >= h)
                return;
            head = screen[r+1][0];
            if (head == CH_SPACE)
                return;
            tail = last_nonblank(r);
            screen[r][tail+1] = head;
            r++;
            x = 0;
        end
    endtask

    task automatic line_feed(int v, int h);
        cur_col = 0;
        cur_line++;
        if (cur_line > v - 1)
        begin
            cur_line = v - 1;
            if (top_row + v < h)
                top_row++;
            else
            begin
                for (int r = 0; r + 1 < h; r++)
                    screen[r] = screen[r+1];
                for (int c = 0; c < NCOL; c++)
                    screen[h-1][c] = CH_SPACE;
            end
        end
    endtask

    task automatic rub_out(int h);
        int prv, nxt, join_col, pos;
        if (cur_col > 0)
        begin
            cur_col--;
            delete_cell(top_row + cur_line, cur_col, h);
            return;
        end
        if (cur_line > 0)
            cur_line--;
        else if (top_row > 0)
            top_row--;
        else
            return;
        prv = top_row + cur_line;
        nxt = prv + 1;
        join_col = last_nonblank(prv) + 1;
        if (join_col >= NCOL)
            join_col = NCOL - 1;
        pos = join_col;
        while (pos < NCOL && nxt < h && screen[nxt][0] != CH_SPACE)
        begin
            screen[prv][pos] = screen[nxt][0];
            pos++;
            delete_cell(nxt, 0, h);
        end
        cur_col = join_col;
    endtask

    task automatic edit_step(in_item_t it, output out_item_t res);
        int v, h;
        int rd_byte, hit;
        v = vis_reg;
        if (v < 1) v = 1;
        if (v > VIS_MAX) v = VIS_MAX;
        if (v > NROW) v = NROW;
        h = hist_reg;
        if (h < v) h = v;
        if (h > NROW) h = NROW;
        rd_byte = 0;
        hit = 0;
        // registers may have moved under the cursor and the view
        if (cur_line > v - 1) cur_line = v - 1;
        if (top_row + v > h) top_row = h - v;
        if (cur_col >= NCOL) cur_col = NCOL - 1;
        case (it.kind)
            KIND_PUT:
            begin
                if (it.char_code == CH_LF || it.char_code == CH_CR)
                    line_feed(v, h);
                else if (it.char_code == CH_BS || it.char_code == CH_DEL)
                    rub_out(h);
                else
                begin
                    screen[top_row + cur_line][cur_col] = it.char_code;
                    cur_col++;
                    if (cur_col >= NCOL)
                        line_feed(v, h);
                end
            end
            KIND_UP:
                if (top_row > 0) top_row--;
            KIND_DOWN:
                if (top_row + v < h) top_row++;
            default:
                if (it.view_row < v && it.column < NCOL)
                begin
                    rd_byte = screen[top_row + it.view_row][it.column];
                    hit = (it.view_row == cur_line && it.column == cur_col);
                end
        endcase
        res.cursor_col  = cur_col[7:0];
        res.cursor_row  = cur_line[5:0];
        res.view_base   = top_row[6:0];
        res.cell_char   = rd_byte[7:0];
        res.at_cursor   = hit[0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want, got;
        if (!rst_n)
        begin
            for (int r = 0; r < NROW; r++)
                for (int c = 0; c < NCOL; c++)
                    screen[r][c] = CH_SPACE;
            cur_col = 0;
            cur_line = 0;
            top_row = 0;
            vis_reg = VIS_RESET;
            hist_reg = HIST_RESET;
            errors = 0;
            due_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VISIBLE)
                    vis_reg = cfg_data[6:0];
                else if (cfg_index == REG_HISTORY)
                    hist_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                edit_step(in_data, want);
                due_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (due_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got.cursor_col !== want.cursor_col)
                    begin
                        $error("cursor_col exp %0d got %0d", want.cursor_col, got.cursor_col);
                        errors++;
                    end
                    if (got.cursor_row !== want.cursor_row)
                    begin
                        $error("cursor_row exp %0d got %0d", want.cursor_row, got.cursor_row);
                        errors++;
                    end
                    if (got.view_base !== want.view_base)
                    begin
                        $error("view_base exp %0d got %0d", want.view_base,
                               got.view_base);
                        errors++;
                    end
                    if (got.cell_char !== want.cell_char)
                    begin
                        $error("cell_char exp %0d got %0d", want.cell_char, got.cell_char);
                        errors++;
                    end
                    if (got.at_cursor !== want.at_cursor)
                    begin
                        $error("at_cursor exp %0d got %0d", want.at_cursor, got.at_cursor);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the console line editor. All checking sits in
// tcle_checker; this module only drives transactions and waits.
module tb_top;
    import tcle_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int        errors;
    int        pending;
    bit        calm;        // no idling on either side while set

    text_console_line_editor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcle_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side back-pressure, about a quarter of the cycles
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 26);

    // Backspace reflow and full-history shifts walk the store byte by byte,
    // hence the wide margin.
    initial
    begin
        #300ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // one input transaction; valid held until taken, then maybe a gap
    task automatic send(in_item_t it);
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 26)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic put(logic [7:0] ch);
        in_item_t it;
        it = '0;
        it.kind = KIND_PUT;
        it.char_code = ch;
        send(it);
    endtask

    task automatic cmd(kind_t k, logic [5:0] vr, logic [7:0] col);
        in_item_t it;
        it.kind = k;
        it.char_code = 8'($urandom);
        it.view_row = vr;
        it.column = col;
        send(it);
    endtask

    // let every result come back before touching the registers
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly typing with spaces, line ends and rub-outs; some scrolls and reads
    task automatic random_item();
        in_item_t it;
        int p, q;
        p = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        it.view_row = (q < 80) ? 6'($urandom_range(0, 7)) : 6'($urandom);
        it.column   = (q < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom);
        it.char_code = 8'($urandom);
        if (p < 62)
        begin
            it.kind = KIND_PUT;
            if (q < 25)      it.char_code = CH_SPACE;
            else if (q < 33) it.char_code = CH_LF;
            else if (q < 37) it.char_code = CH_CR;
            else if (q < 46) it.char_code = CH_BS;
            else if (q < 50) it.char_code = CH_DEL;
            else if (q < 80) it.char_code = 8'($urandom_range(33, 126));
        end
        else if (p < 70) it.kind = KIND_UP;
        else if (p < 78) it.kind = KIND_DOWN;
        else             it.kind = KIND_READ;
        send(it);
    endtask

    task automatic phase(logic [7:0] vis, logic [7:0] hist, int count);
        drain();
        write_reg(REG_VISIBLE, vis);
        write_reg(REG_HISTORY, hist);
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= 40 && n < 90);
            random_item();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_VISIBLE;
        cfg_data  = '0;
        calm      = 1'b0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: rub-out at the very top does nothing, then field extremes
        put(CH_BS);
        put(CH_DEL);
        cmd(KIND_UP, 6'd0, 8'd0);
        put(8'd65);
        put(8'd255);
        put(8'd0);
        put(CH_CR);
        put(8'd66);
        put(CH_LF);
        cmd(KIND_DOWN, 6'd0, 8'd0);
        cmd(KIND_UP, 6'd0, 8'd0);
        cmd(KIND_READ, 6'd0, 8'd0);
        cmd(KIND_READ, 6'd1, 8'd1);
        cmd(KIND_READ, 6'd1, 8'd0);
        cmd(KIND_READ, 6'd63, 8'd255);
        cmd(KIND_READ, 6'd23, 8'd159);
        cmd(KIND_READ, 6'd0, 8'd160);
        put(CH_BS);                 // merge into the row above
        put(CH_BS);                 // delete inside the line

        // a row filled to the last column wraps by itself; tiny history shifts
        drain();
        write_reg(REG_VISIBLE, 8'd2);
        write_reg(REG_HISTORY, 8'd2);
        for (int i = 0; i < COLUMNS_DEF + 2; i++)
            put(8'd97 + 8'(i % 26));
        put(CH_LF);
        put(CH_LF);
        cmd(KIND_READ, 6'd0, 8'd0);
        put(CH_BS);

        phase(8'd4,   8'd8,   150);
        phase(8'd1,   8'd1,   40);
        phase(8'd0,   8'd0,   20);
        phase(8'd3,   8'd5,   90);
        phase(8'd64,  8'd128, 30);
        phase(8'd127, 8'd255, 20);
        phase(8'd8,   8'd6,   65);

        drain();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: text_console_line_editor_core.f
+incdir+design
design/tcle_pkg.sv
design/tcle_datapath.sv
design/tcle_ctrl.sv
design/text_console_line_editor_core.sv
bench/tcle_checker.sv
bench/tb_top.sv
